/* rtl/core/cab_pkg.sv */
// Shared constants, types and helpers for the clipped ARGB pixel blend.
package cab_pkg;

  // Largest surface edge; clip right/bottom edges saturate here.
  localparam int SURFACE_DIM_MAX = 4096;

  localparam int COORD_W    = 16;
  localparam int POS_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Signed compare width: holds any coordinate, left+width and SURFACE_DIM_MAX.
  localparam int CMP_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT = 3'd3;

  localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [POS_W-1:0]  left;
    logic [POS_W-1:0]  top;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } clip_cfg_t;

  // 4444 -> 8888: nibble * 17 is the nibble repeated twice.
  function automatic logic [PIX_W-1:0] widen4444(input logic [15:0] p);
    return {p[15:12], p[15:12], p[11:8], p[11:8], p[7:4], p[7:4], p[3:0], p[3:0]};
  endfunction

endpackage

/* rtl/core/cab_clip.sv */
// Clip rectangle inside test for one pixel coordinate.
module cab_clip (
  input  cab_pkg::clip_cfg_t               cfg,
  input  logic [cab_pkg::COORD_W-1:0]      pixel_x,
  input  logic [cab_pkg::COORD_W-1:0]      pixel_y,
  output logic                             in_clip
);

  localparam logic [cab_pkg::CMP_W-1:0] DIM_MAX = cab_pkg::CMP_W'(cab_pkg::SURFACE_DIM_MAX);

  logic [cab_pkg::CMP_W-1:0] left_e, top_e, right_sum, bottom_sum, right_e, bottom_e;
  logic [cab_pkg::CMP_W-1:0] x_e, y_e;

  always_comb begin
    left_e     = cab_pkg::CMP_W'(cfg.left);
    top_e      = cab_pkg::CMP_W'(cfg.top);
    right_sum  = left_e + cab_pkg::CMP_W'(cfg.width);
    bottom_sum = top_e + cab_pkg::CMP_W'(cfg.height);
    right_e    = (right_sum > DIM_MAX) ? DIM_MAX : right_sum;
    bottom_e   = (bottom_sum > DIM_MAX) ? DIM_MAX : bottom_sum;
    x_e = {{(cab_pkg::CMP_W - cab_pkg::COORD_W){pixel_x[cab_pkg::COORD_W-1]}}, pixel_x};
    y_e = {{(cab_pkg::CMP_W - cab_pkg::COORD_W){pixel_y[cab_pkg::COORD_W-1]}}, pixel_y};
    in_clip = ($signed(x_e) >= $signed(left_e)) && ($signed(x_e) < $signed(right_e)) &&
              ($signed(y_e) >= $signed(top_e))  && ($signed(y_e) < $signed(bottom_e));
  end

endmodule

/* rtl/core/cab_mix.sv */
// One color channel blend: (s*a + d*(255-a)) / 255, truncated.
module cab_mix (
  input  logic [cab_pkg::CH_W-1:0] src,
  input  logic [cab_pkg::CH_W-1:0] dst,
  input  logic [cab_pkg::CH_W-1:0] alpha,
  output logic [cab_pkg::CH_W-1:0] mixed
);

  logic [2*cab_pkg::CH_W-1:0] inv_a;
  logic [2*cab_pkg::CH_W-1:0] sum;
  logic [2*cab_pkg::CH_W:0]   adj;

  always_comb begin
    inv_a = (2*cab_pkg::CH_W)'(cab_pkg::ALPHA_OPAQUE - alpha);
    // at most 255*255, fits 16 bits
    sum = (2*cab_pkg::CH_W)'(src) * (2*cab_pkg::CH_W)'(alpha) +
          (2*cab_pkg::CH_W)'(dst) * inv_a;
    // exact floor(v/255) for v up to 255*255: (v + 1 + (v >> 8)) >> 8
    adj = (2*cab_pkg::CH_W+1)'(sum) + (2*cab_pkg::CH_W+1)'(1) +
          (2*cab_pkg::CH_W+1)'(sum >> cab_pkg::CH_W);
    mixed = adj[2*cab_pkg::CH_W-1:cab_pkg::CH_W];
  end

endmodule

/* rtl/core/clipped_argb_pixel_blend.sv */
// Top level of the clipped ARGB pixel blend: input register, blend logic, result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  in      | input     | in_valid/in_stall  | pixel_x, pixel_y, source_format,
//          |           |                    | source_pixel, dest_pixel
//  out     | output    | out_valid/out_stall| write_enable, pixel_out
//  cfg     | input     | cfg_we             | cfg_index, cfg_wdata (clip rectangle)
//
// One item per clock sustained while out_stall is low; an accepted item is held in the input
// register, then in the result register, which drives out_valid and the outputs. The
// clip test, the 4444 widening and the three channel multiply/divide-by-255 paths sit
// between those two registers.
// Reset (rst_n low, synchronous) empties both stages and clears the clip rectangle
// to zero size, so nothing is written until it is configured.
// out_stall holds the result register; in_stall rises only when the input stage holds
// an item that cannot move into a full, stalled result register.
module clipped_argb_pixel_blend (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cab_pkg::COORD_W-1:0]       in_pixel_x,
  input  logic [cab_pkg::COORD_W-1:0]       in_pixel_y,
  input  logic                              in_source_format,
  input  logic [cab_pkg::PIX_W-1:0]         in_source_pixel,
  input  logic [cab_pkg::PIX_W-1:0]         in_dest_pixel,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_write_enable,
  output logic [cab_pkg::PIX_W-1:0]         out_pixel_out,

  input  logic                              cfg_we,
  input  logic [cab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cab_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // Clip rectangle registers
  cab_pkg::clip_cfg_t clip_r, clip_nxt;

  always_comb begin
    clip_nxt = clip_r;
    if (cfg_we) begin
      case (cfg_index)
        cab_pkg::REG_CLIP_LEFT:   clip_nxt.left   = cfg_wdata[cab_pkg::POS_W-1:0];
        cab_pkg::REG_CLIP_TOP:    clip_nxt.top    = cfg_wdata[cab_pkg::POS_W-1:0];
        cab_pkg::REG_CLIP_WIDTH:  clip_nxt.width  = cfg_wdata[cab_pkg::SIZE_W-1:0];
        cab_pkg::REG_CLIP_HEIGHT: clip_nxt.height = cfg_wdata[cab_pkg::SIZE_W-1:0];
        default:                  clip_nxt = clip_r;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= '0;
    end else begin
      clip_r <= clip_nxt;
    end
  end

  // Pipeline control
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, s1_adv, in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_free ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input stage payload
  logic [cab_pkg::COORD_W-1:0] x_r, y_r;
  logic                        fmt_r;
  logic [cab_pkg::PIX_W-1:0]   src_r, dst_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r   <= in_pixel_x;
      y_r   <= in_pixel_y;
      fmt_r <= in_source_format;
      src_r <= in_source_pixel;
      dst_r <= in_dest_pixel;
    end
  end

  // Blend logic
  logic                      in_clip;
  logic [cab_pkg::PIX_W-1:0] src_w;
  logic [cab_pkg::CH_W-1:0]  alpha, red_mix, grn_mix, blu_mix;
  logic                      we_nxt;
  logic [cab_pkg::PIX_W-1:0] pix_nxt;

  assign src_w = fmt_r ? cab_pkg::widen4444(src_r[15:0]) : src_r;
  assign alpha = src_w[31:24];

  cab_clip u_clip (
    .cfg     (clip_r),
    .pixel_x (x_r),
    .pixel_y (y_r),
    .in_clip (in_clip)
  );

  cab_mix u_mix_r (.src(src_w[23:16]), .dst(dst_r[23:16]), .alpha(alpha), .mixed(red_mix));
  cab_mix u_mix_g (.src(src_w[15:8]),  .dst(dst_r[15:8]),  .alpha(alpha), .mixed(grn_mix));
  cab_mix u_mix_b (.src(src_w[7:0]),   .dst(dst_r[7:0]),   .alpha(alpha), .mixed(blu_mix));

  always_comb begin
    we_nxt = in_clip && (alpha != cab_pkg::ALPHA_CLEAR);
    if (!we_nxt) begin
      pix_nxt = '0;                       // no write: value reads as zero
    end else if (alpha == cab_pkg::ALPHA_OPAQUE) begin
      pix_nxt = src_w;                    // opaque source passes unchanged
    end else begin
      pix_nxt = {cab_pkg::ALPHA_OPAQUE, red_mix, grn_mix, blu_mix};
    end
  end

  // Result register
  logic                      we_r;
  logic [cab_pkg::PIX_W-1:0] pix_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      we_r  <= we_nxt;
      pix_r <= pix_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = we_r;
  assign out_pixel_out    = pix_r;

endmodule
